>>> design/lssr_pkg.sv
// Package for the lidar scan sector reducer: point and result types,
// field widths, register indexes and register reset values.
// No dependencies.
`timescale 1ns / 1ps

package lssr_pkg;

    // Field widths
    localparam int ANGLE_W = 15;
    localparam int DIST_W  = 16;
    localparam int COUNT_W = 8;
    localparam int PHASE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBJ_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_EVERY   = 2'd3;

    // Register reset values
    localparam logic [ANGLE_W-1:0] SECTOR_START_RST = 15'd0;
    localparam logic [ANGLE_W-1:0] SECTOR_END_RST   = 15'd11520;
    localparam logic [DIST_W-1:0]  OBJ_THRESH_RST   = 16'd1200;
    localparam logic [PHASE_W-1:0] KEEP_EVERY_RST   = 8'd5;

    // Scan state reset value and tally saturation limit
    localparam logic [DIST_W-1:0]  NEAR_DIST_RST = '1;
    localparam logic [COUNT_W-1:0] TALLY_MAX     = '1;

    // One input point
    typedef struct packed {
        logic               scan_start;
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  distance;
    } point_t;

    // One scan summary
    typedef struct packed {
        logic [COUNT_W-1:0] object_count;
        logic [DIST_W-1:0]  nearest_distance;
        logic [ANGLE_W-1:0] nearest_angle;
        logic               nearest_found;
    } result_t;

endpackage

>>> design/lssr_in_stage.sv
// Input register stage with a skid entry, so s_ready comes from a flop.
// Depends on lssr_pkg for point_t.
`timescale 1ns / 1ps

module lssr_in_stage
    import lssr_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  point_t in_point,
    output logic   out_valid,
    input  logic   out_take,
    output point_t out_point
);

    logic   main_valid_reg;
    logic   skid_valid_reg;
    point_t main_reg;
    point_t skid_reg;
    logic   push;
    logic   pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_take;
    assign out_valid = main_valid_reg;
    assign out_point = main_reg;

    // Control: main holds the head request, skid catches one during a stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || pop) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || pop) begin
            main_reg <= skid_valid_reg ? skid_reg : in_point;
        end else if (push) begin
            skid_reg <= in_point;
        end
    end

endmodule

>>> design/lssr_core.sv
// Scan state, configuration registers and the per-point update logic.
// Depends on lssr_pkg for types, widths and register indexes.
`timescale 1ns / 1ps

module lssr_core
    import lssr_pkg::*;
#(
    parameter int SAMPLE_LIMIT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // point from the input stage
    input  logic                  pt_valid,
    output logic                  pt_take,
    input  point_t                pt,
    // summary to the output stage
    input  logic                  res_ready,
    output logic                  res_push,
    output result_t               res
);

    localparam int KEPT_W = $clog2(SAMPLE_LIMIT + 1);

    // Configuration registers
    logic [ANGLE_W-1:0] sector_start_reg;
    logic [ANGLE_W-1:0] sector_end_reg;
    logic [DIST_W-1:0]  obj_thresh_reg;
    logic [PHASE_W-1:0] keep_every_reg;

    // Scan state
    logic [PHASE_W-1:0] phase_reg,      phase_next;
    logic [KEPT_W-1:0]  kept_reg,       kept_next;
    logic [DIST_W-1:0]  near_dist_reg,  near_dist_next;
    logic [ANGLE_W-1:0] near_angle_reg, near_angle_next;
    logic               seen_reg,       seen_next;
    logic               inside_reg,     inside_next;
    logic [COUNT_W-1:0] tally_reg,      tally_next;

    logic               fire;
    logic               is_start;
    logic [PHASE_W-1:0] period;
    logic [PHASE_W:0]   phase_inc;
    logic               in_sector;
    logic               kept;

    assign is_start = pt.scan_start;
    assign pt_take  = pt_valid && (!is_start || res_ready);
    assign fire     = pt_take;
    assign res_push = fire && is_start;

    // Summary of the finished scan
    always_comb begin
        res.object_count     = tally_reg;
        res.nearest_distance = seen_reg ? near_dist_reg : '0;
        res.nearest_angle    = seen_reg ? near_angle_reg : '0;
        res.nearest_found    = seen_reg;
    end

    // Configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_start_reg <= SECTOR_START_RST;
            sector_end_reg   <= SECTOR_END_RST;
            obj_thresh_reg   <= OBJ_THRESH_RST;
            keep_every_reg   <= KEEP_EVERY_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SECTOR_START: sector_start_reg <= cfg_data[ANGLE_W-1:0];
                REG_SECTOR_END:   sector_end_reg   <= cfg_data[ANGLE_W-1:0];
                REG_OBJ_THRESH:   obj_thresh_reg   <= cfg_data[DIST_W-1:0];
                REG_KEEP_EVERY:   keep_every_reg   <= cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Keep phase: advance and wrap at the period (zero period acts as one)
    assign period    = (keep_every_reg == '0) ? PHASE_W'(1) : keep_every_reg;
    assign phase_inc = {1'b0, phase_reg} + (PHASE_W+1)'(1);
    assign in_sector = (pt.angle >= sector_start_reg) && (pt.angle < sector_end_reg);

    always_comb begin
        phase_next = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[PHASE_W-1:0];
        kept       = (phase_next == '0) && (kept_reg < KEPT_W'(SAMPLE_LIMIT));
    end

    // Next scan state for one non-start point
    always_comb begin
        kept_next       = kept_reg;
        near_dist_next  = near_dist_reg;
        near_angle_next = near_angle_reg;
        seen_next       = seen_reg;
        inside_next     = inside_reg;
        tally_next      = tally_reg;
        if (in_sector) begin
            // nearest nonzero return
            if ((pt.distance != '0) && (!seen_reg || pt.distance < near_dist_reg)) begin
                near_dist_next  = pt.distance;
                near_angle_next = pt.angle;
                seen_next       = 1'b1;
            end
            // object counter on kept samples
            if (kept) begin
                kept_next = kept_reg + KEPT_W'(1);
                if (!inside_reg && pt.distance < obj_thresh_reg) begin
                    inside_next = 1'b1;
                    if (tally_reg != TALLY_MAX) begin
                        tally_next = tally_reg + COUNT_W'(1);
                    end
                end else if (inside_reg && pt.distance > obj_thresh_reg) begin
                    inside_next = 1'b0;
                end
            end
        end
    end

    // State registers: a start point clears the scan
    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && is_start)) begin
            phase_reg      <= '0;
            kept_reg       <= '0;
            near_dist_reg  <= NEAR_DIST_RST;
            near_angle_reg <= '0;
            seen_reg       <= 1'b0;
            inside_reg     <= 1'b0;
            tally_reg      <= '0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            kept_reg       <= kept_next;
            near_dist_reg  <= near_dist_next;
            near_angle_reg <= near_angle_next;
            seen_reg       <= seen_next;
            inside_reg     <= inside_next;
            tally_reg      <= tally_next;
        end
    end

    // Checks
    a_unseen_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> (near_dist_reg == NEAR_DIST_RST) && (near_angle_reg == '0))
        else $error("nearest point held without seen flag");

    a_kept_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_reg <= KEPT_W'(SAMPLE_LIMIT))
        else $error("kept sample count above limit");

    a_tally_needs_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (tally_reg != '0) |-> (kept_reg != '0))
        else $error("object counted without a kept sample");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |=> (tally_reg == '0) && (kept_reg == '0) && !seen_reg && !inside_reg)
        else $error("scan state not cleared after start point");

endmodule

>>> design/lssr_out_stage.sv
// Result register holding one scan summary until the consumer takes it.
// Depends on lssr_pkg for result_t.
`timescale 1ns / 1ps

module lssr_out_stage
    import lssr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_push,
    output logic    in_ready,
    input  result_t in_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_push;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_push && in_ready) begin
            res_reg <= in_res;
        end
    end

endmodule

>>> design/lidar_scan_sector_reducer.sv
// Lidar scan sector reducer top level: input stage, scan core, result register.
// A start point passes through the input stage register; its summary is written into the
// result register when the core takes it, once nothing is queued ahead of it in the input stage.
// Throughput: one point per cycle; a start point waits while the result register is full,
// and the points behind it wait with it.
// Reset (aresetn, synchronous, active low) loads the register defaults and clears scan state.
// Depends on lssr_pkg, lssr_in_stage, lssr_core and lssr_out_stage.
`timescale 1ns / 1ps

module lidar_scan_sector_reducer
    import lssr_pkg::*;
#(
    parameter int SAMPLE_LIMIT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // points in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_scan_start,
    input  logic [ANGLE_W-1:0]    s_angle,
    input  logic [DIST_W-1:0]     s_distance,
    // summaries out
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_W-1:0]    m_object_count,
    output logic [DIST_W-1:0]     m_nearest_distance,
    output logic [ANGLE_W-1:0]    m_nearest_angle,
    output logic                  m_nearest_found
);

    point_t  in_point;
    point_t  pt;
    logic    pt_valid;
    logic    pt_take;
    logic    res_ready;
    logic    res_push;
    result_t res;
    result_t out_res;

    assign cfg_ready = 1'b1;

    assign in_point.scan_start = s_scan_start;
    assign in_point.angle      = s_angle;
    assign in_point.distance   = s_distance;

    lssr_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_point  (in_point),
        .out_valid (pt_valid),
        .out_take  (pt_take),
        .out_point (pt)
    );

    lssr_core #(
        .SAMPLE_LIMIT (SAMPLE_LIMIT)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pt_valid  (pt_valid),
        .pt_take   (pt_take),
        .pt        (pt),
        .res_ready (res_ready),
        .res_push  (res_push),
        .res       (res)
    );

    lssr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_push   (res_push),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_object_count     = out_res.object_count;
    assign m_nearest_distance = out_res.nearest_distance;
    assign m_nearest_angle    = out_res.nearest_angle;
    assign m_nearest_found    = out_res.nearest_found;

endmodule

>>> bench/lssr_checker.sv
`timescale 1ns / 1ps
// Scan summary checker for the lidar scan sector reducer: follows register writes,
// predicts each summary from accepted point requests and compares accepted results.
// Depends on lssr_pkg.

module lssr_checker
    import lssr_pkg::*;
#(
    parameter int SAMPLE_LIMIT = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_scan_start,
    input  logic [ANGLE_W-1:0]    s_angle,
    input  logic [DIST_W-1:0]     s_distance,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [COUNT_W-1:0]    m_object_count,
    input  logic [DIST_W-1:0]     m_nearest_distance,
    input  logic [ANGLE_W-1:0]    m_nearest_angle,
    input  logic                  m_nearest_found,
    output int                    fail_count,
    output int                    pending
);

    // Register copy
    logic [ANGLE_W-1:0] sec_lo;
    logic [ANGLE_W-1:0] sec_hi;
    logic [DIST_W-1:0]  obj_thresh;
    logic [PHASE_W-1:0] keep_period;

    // Scan state copy
    logic [PHASE_W-1:0] keep_phase;
    int                 kept;
    logic [DIST_W-1:0]  near_dist;
    logic [ANGLE_W-1:0] near_angle;
    logic               near_seen;
    logic               in_object;
    logic [COUNT_W-1:0] tally;

    // Summaries predicted but not yet seen on the result channel
    result_t summary_q[$];

    function automatic void clear_scan();
        keep_phase = '0;
        kept       = 0;
        near_dist  = NEAR_DIST_RST;
        near_angle = '0;
        near_seen  = 1'b0;
        in_object  = 1'b0;
        tally      = '0;
    endfunction

    // Fold one point into the scan; a start point closes the scan with a summary
    function automatic void reduce_point(input point_t pt);
        int      period;
        int      ph;
        result_t sum;
        if (pt.scan_start) begin
            sum.object_count     = tally;
            sum.nearest_distance = near_seen ? near_dist : '0;
            sum.nearest_angle    = near_seen ? near_angle : '0;
            sum.nearest_found    = near_seen;
            summary_q.push_back(sum);
            clear_scan();
        end else begin
            // keep_every of zero acts as one; a stale phase above it wraps
            period = (keep_period == 0) ? 1 : int'(keep_period);
            ph = int'(keep_phase) + 1;
            if (ph >= period) begin
                ph = 0;
            end
            keep_phase = ph[PHASE_W-1:0];
            if (pt.angle >= sec_lo && pt.angle < sec_hi) begin
                if (pt.distance != 0 && (!near_seen || pt.distance < near_dist)) begin
                    near_dist  = pt.distance;
                    near_angle = pt.angle;
                    near_seen  = 1'b1;
                end
                // two-state object counter on kept samples
                if (keep_phase == 0 && kept < SAMPLE_LIMIT) begin
                    kept++;
                    if (!in_object && pt.distance < obj_thresh) begin
                        if (tally != TALLY_MAX) begin
                            tally++;
                        end
                        in_object = 1'b1;
                    end
                    if (in_object && pt.distance > obj_thresh) begin
                        in_object = 1'b0;
                    end
                end
            end
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        point_t  pt;
        result_t want;
        if (!aresetn) begin
            sec_lo      = SECTOR_START_RST;
            sec_hi      = SECTOR_END_RST;
            obj_thresh  = OBJ_THRESH_RST;
            keep_period = KEEP_EVERY_RST;
            clear_scan();
            summary_q.delete();
            fail_count = 0;
        end else begin
            // register write request
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SECTOR_START: sec_lo      = cfg_data[ANGLE_W-1:0];
                    REG_SECTOR_END:   sec_hi      = cfg_data[ANGLE_W-1:0];
                    REG_OBJ_THRESH:   obj_thresh  = cfg_data[DIST_W-1:0];
                    REG_KEEP_EVERY:   keep_period = cfg_data[PHASE_W-1:0];
                    default: ;
                endcase
            end
            // point request
            if (s_valid && s_ready) begin
                pt = {s_scan_start, s_angle, s_distance};
                reduce_point(pt);
            end
            // summary request
            if (m_valid && m_ready) begin
                if (summary_q.size() == 0) begin
                    $display("%0t: unexpected summary, expected none, actual %0d %0d %0d %0d",
                             $time, m_object_count, m_nearest_distance, m_nearest_angle,
                             m_nearest_found);
                    fail_count++;
                end else begin
                    want = summary_q.pop_front();
                    compare_field("object_count", 32'(want.object_count),
                                  32'(m_object_count));
                    compare_field("nearest_distance", 32'(want.nearest_distance),
                                  32'(m_nearest_distance));
                    compare_field("nearest_angle", 32'(want.nearest_angle),
                                  32'(m_nearest_angle));
                    compare_field("nearest_found", 32'(want.nearest_found),
                                  32'(m_nearest_found));
                end
            end
        end
        pending <= summary_q.size();
    end

endmodule

>>> bench/lidar_scan_sector_reducer_test.sv
`timescale 1ns / 1ps
// Test top for the lidar scan sector reducer: clock, reset, point and register
// stimulus, result-side stalls and the verdict. Depends on lssr_pkg and lssr_checker.

module lidar_scan_sector_reducer_test;
    import lssr_pkg::*;

    localparam int SAMPLE_LIMIT  = 256;
    localparam int POINT_TARGET  = 650;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_SCAN     = 270;
    localparam int ANGLE_MAX     = 32767;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_scan_start;
    logic [ANGLE_W-1:0]    s_angle;
    logic [DIST_W-1:0]     s_distance;
    logic                  m_valid;
    logic                  m_ready;
    logic [COUNT_W-1:0]    m_object_count;
    logic [DIST_W-1:0]     m_nearest_distance;
    logic [ANGLE_W-1:0]    m_nearest_angle;
    logic                  m_nearest_found;

    int fail_count;
    int pending;
    int points_sent;
    bit tx_calm;
    bit rx_calm;
    // register values last written, used to aim the stimulus
    int cur_lo, cur_hi, cur_thr, cur_keep;

    always #4 aclk = ~aclk;

    lidar_scan_sector_reducer #(
        .SAMPLE_LIMIT(SAMPLE_LIMIT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_scan_start(s_scan_start),
        .s_angle(s_angle),
        .s_distance(s_distance),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_object_count(m_object_count),
        .m_nearest_distance(m_nearest_distance),
        .m_nearest_angle(m_nearest_angle),
        .m_nearest_found(m_nearest_found)
    );

    lssr_checker #(
        .SAMPLE_LIMIT(SAMPLE_LIMIT)
    ) summary_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_scan_start(s_scan_start),
        .s_angle(s_angle),
        .s_distance(s_distance),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_object_count(m_object_count),
        .m_nearest_distance(m_nearest_distance),
        .m_nearest_angle(m_nearest_angle),
        .m_nearest_found(m_nearest_found),
        .fail_count(fail_count),
        .pending(pending)
    );

    // One point request; valid stays up into a back-to-back request
    task automatic send_point(input logic start, input int ang, input int dist_mm);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_scan_start <= start;
        s_angle      <= ang[ANGLE_W-1:0];
        s_distance   <= dist_mm[DIST_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        points_sent++;
    endtask

    // One register write request; the caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Stop points, wait for every summary, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stall before each summary
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int phase;
        int budget;
        int scan_len;
        int sel;
        int ang;
        int dist_mm;
        int i;
        aresetn      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_scan_start <= 1'b0;
        s_angle      <= '0;
        s_distance   <= '0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        points_sent  = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed points under reset registers, before any start point
        send_point(1'b0, 0, 0);                    // zero distance, not kept
        send_point(1'b0, SECTOR_END_RST - 1, 65535); // first return, max range
        send_point(1'b0, SECTOR_END_RST, 100);     // sector end is exclusive
        send_point(1'b0, ANGLE_MAX, 5);            // angle past full turn
        send_point(1'b0, 100, 0);                  // kept zero sample is an object
        send_point(1'b1, 23039, 65535);            // start payload is ignored
        send_point(1'b1, 0, 0);                    // empty scan: nothing found
        // every fifth point kept: below, equal, above threshold
        for (i = 0; i < 15; i++) begin
            send_point(1'b0, 200 + i, (i % 5 == 4) ? OBJ_THRESH_RST - 1 + i / 5 : 3000 + i);
        end
        send_point(1'b1, 1, 1);
        settle();

        for (phase = 0; points_sent < POINT_TARGET; phase++) begin
            // register settings: extremes first, then random
            case (phase)
                0: begin
                    cur_lo = 0; cur_hi = 23040; cur_thr = 0; cur_keep = 1;
                end
                1: begin
                    cur_lo = 23039; cur_hi = 23040; cur_thr = 65535; cur_keep = 255;
                end
                2: begin
                    cur_lo = 5000; cur_hi = 5000; cur_thr = 1200; cur_keep = 3;
                end
                3: begin
                    cur_lo = ANGLE_MAX; cur_hi = 0; cur_thr = 1; cur_keep = 0;
                end
                4: begin
                    cur_lo = 0; cur_hi = ANGLE_MAX; cur_thr = 1000; cur_keep = 1;
                end
                default: begin
                    cur_lo = $urandom_range(0, 23039);
                    cur_hi = cur_lo + $urandom_range(1, 8000);
                    if (cur_hi > 23040) begin
                        cur_hi = 23040;
                    end
                    if ($urandom_range(0, 7) == 0) begin
                        cur_lo = $urandom_range(0, ANGLE_MAX);
                        cur_hi = $urandom_range(0, ANGLE_MAX);
                    end
                    cur_thr = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                   : $urandom_range(200, 3000);
                    cur_keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(1, 8);
                end
            endcase
            // upper data bits beyond each register's width are don't-care
            write_reg(REG_SECTOR_START, cur_lo | ($urandom_range(0, 1) << 15));
            write_reg(REG_SECTOR_END, cur_hi | ($urandom_range(0, 1) << 15));
            write_reg(REG_OBJ_THRESH, cur_thr);
            write_reg(REG_KEEP_EVERY, cur_keep | ($urandom_range(0, 255) << 8));
            cfg_valid <= 1'b0;
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);

            if (phase == 4) begin
                // one long scan past the sample limit, alternating near and far
                send_point(1'b1, 0, 0);
                for (i = 0; i < LONG_SCAN; i++) begin
                    send_point(1'b0, $urandom_range(0, ANGLE_MAX - 1),
                               (i % 2 == 0) ? $urandom_range(0, 999)
                                            : $urandom_range(1001, 65535));
                end
                send_point(1'b1, ANGLE_MAX, 65535);
            end else begin
                budget = points_sent + $urandom_range(30, 60);
                while (points_sent < budget) begin
                    scan_len = $urandom_range(0, 14);
                    send_point(1'b1, $urandom_range(0, ANGLE_MAX), $urandom_range(0, 65535));
                    repeat (scan_len) begin
                        // angle: mostly inside the sector, some anywhere, some at bounds
                        sel = $urandom_range(0, 9);
                        if (sel < 7 && cur_lo < cur_hi) begin
                            ang = $urandom_range(cur_lo, cur_hi - 1);
                        end else if (sel <= 7) begin
                            ang = $urandom_range(0, ANGLE_MAX);
                        end else if (sel == 8) begin
                            ang = (cur_lo - $urandom_range(0, 1)) & ANGLE_MAX;
                        end else begin
                            ang = (cur_hi - $urandom_range(0, 1)) & ANGLE_MAX;
                        end
                        // distance: mostly around the threshold to toggle the counter
                        sel = $urandom_range(0, 9);
                        if (sel == 0) begin
                            dist_mm = 0;
                        end else if (sel == 1) begin
                            dist_mm = 65535;
                        end else if (sel < 7) begin
                            dist_mm = cur_thr + $urandom_range(0, 6) - 3;
                            if (dist_mm < 0) begin
                                dist_mm = 0;
                            end else if (dist_mm > 65535) begin
                                dist_mm = 65535;
                            end
                        end else begin
                            dist_mm = $urandom_range(0, 65535);
                        end
                        send_point(1'b0, ang, dist_mm);
                    end
                end
            end
            // scan state may stay open across the next register change
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin : watchdog
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
design/lssr_pkg.sv
design/lssr_in_stage.sv
design/lssr_core.sv
design/lssr_out_stage.sv
design/lidar_scan_sector_reducer.sv
bench/lssr_checker.sv
bench/lidar_scan_sector_reducer_test.sv
